// ===== src/assert_macros.svh =====
// assertion macros used by the checker file ffdza_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define FFDZA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// property checked at every rising clock edge, reset included
`define FFDZA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

// ===== src/ffdza_pkg.sv =====
// types, codes and constants of the first-fit disk zone allocator
`timescale 1ns / 1ps

package ffdza_pkg;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NOEMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPC = 1'b1;

    localparam logic [5:0] RPT_RESET = 6'd6;
    localparam logic [7:0] TPC_RESET = 8'd20;

    // table contents after reset
    localparam int unsigned INIT_COUNT = 3;
    localparam logic [15:0] INIT_START [INIT_COUNT] = '{16'd5, 16'd14, 16'd21};
    localparam logic [15:0] INIT_LEN   [INIT_COUNT] = '{16'd6, 16'd3, 16'd30};

    typedef struct packed {
        logic        action;
        logic [15:0] block_length;
        logic [15:0] cylinder_in;
        logic [7:0]  track_in;
        logic [5:0]  record_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] cylinder_out;
        logic [7:0]  track_out;
        logic [5:0]  record_out;
    } t_out_item;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL1 = 7'b0000010,
        S_MUL2 = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_DIV1 = 7'b0010000,
        S_DIV2 = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    typedef struct packed {
        logic       load_item;
        logic       mul_a;
        logic       mul_b;
        logic       scan_next;
        logic       wr_alloc;
        logic       wr_free;
        logic       set_status;
        logic [1:0] status;
        logic       div_start_a;
        logic       div_start_b;
        logic       div_step;
        logic       div_finish;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic range_err;
        logic hit;
        logic last;
        logic div_done;
    } t_sts;

    function automatic logic [15:0] init_start(input logic [31:0] idx);
        logic [15:0] v;
        v = '0;
        if (idx < INIT_COUNT) begin
            v = INIT_START[idx[1:0]];
        end
        return v;
    endfunction

    function automatic logic [15:0] init_len(input logic [31:0] idx);
        logic [15:0] v;
        v = '0;
        if (idx < INIT_COUNT) begin
            v = INIT_LEN[idx[1:0]];
        end
        return v;
    endfunction

endpackage

// ===== src/ffdza_ctrl.sv =====
// controller state machine of the zone allocator
`timescale 1ns / 1ps

module ffdza_ctrl
    import ffdza_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall,
    output logic o_out_valid
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_SCAN;
                    if (i_sts.is_free) begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                o_cmd.mul_a = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_b = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                priority if (i_sts.is_free && i_sts.range_err) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_RANGE;
                    n_state = S_DONE;
                end else if (i_sts.hit) begin
                    if (i_sts.is_free) begin
                        o_cmd.wr_free = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.wr_alloc    = 1'b1;
                        o_cmd.div_start_a = 1'b1;
                        n_state = S_DIV1;
                    end
                end else if (i_sts.last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = i_sts.is_free ? ST_NOEMPTY : ST_NOFIT;
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_DIV1: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start_b = 1'b1;
                    n_state = S_DIV2;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DIV2: begin
                if (i_sts.div_done) begin
                    o_cmd.div_finish = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register stays full while the receiver stalls
    assign n_out_valid = o_cmd.out_load | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/ffdza_dp.sv =====
// datapath of the zone allocator: zone table, multipliers, divider, result register
`timescale 1ns / 1ps

module ffdza_dp
    import ffdza_pkg::*;
#(
    parameter int unsigned ZONE_ENTRIES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  t_in_item              i_in_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out_item             o_out_data
);

    localparam int unsigned IDX_W = $clog2(ZONE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ZONE_ENTRIES - 1);

    // geometry registers
    logic [5:0] r_rpt;
    logic [7:0] r_tpc;
    logic [5:0] rpt_eff;
    logic [7:0] tpc_eff;

    // current item
    logic        r_free;
    logic [15:0] r_len;
    logic [15:0] r_cyl_in;
    logic [7:0]  r_trk_in;
    logic [5:0]  r_rec_in;
    logic [23:0] r_prod;
    logic [29:0] r_block;

    // zone table
    logic [31:0]             r_mem [ZONE_ENTRIES];
    logic [ZONE_ENTRIES-1:0] r_valid;
    logic [ZONE_ENTRIES-1:0] r_empty;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [31:0]             r_rd_word;
    logic                    r_rd_valid;
    logic [15:0]             rd_start;
    logic [15:0]             rd_len;
    logic [15:0]             new_start;
    logic [15:0]             new_len;
    logic                    we;
    logic [31:0]             wdata;

    // shared divider
    logic [15:0] r_quo;
    logic [7:0]  r_rem;
    logic [7:0]  r_dvs;
    logic [4:0]  r_cnt;
    logic [8:0]  trial;
    logic [8:0]  diff;
    logic        ge;

    // result
    logic [1:0]  r_status;
    logic [15:0] r_cyl;
    logic [7:0]  r_trk;
    logic [5:0]  r_rec;
    t_out_item   r_out;

    assign rpt_eff = (r_rpt == '0) ? 6'd1 : r_rpt;
    assign tpc_eff = (r_tpc == '0) ? 8'd1 : r_tpc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpt <= RPT_RESET;
            r_tpc <= TPC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RPT: r_rpt <= i_cfg_data[5:0];
                CFG_TPC: r_tpc <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // item capture and block number
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_free   <= (i_in_data.action == ACT_FREE);
            r_len    <= i_in_data.block_length;
            r_cyl_in <= i_in_data.cylinder_in;
            r_trk_in <= i_in_data.track_in;
            r_rec_in <= i_in_data.record_in;
        end
        if (i_cmd.mul_a) begin
            r_prod <= r_cyl_in * tpc_eff + 24'(r_trk_in);
        end
        if (i_cmd.mul_b) begin
            r_block <= r_prod * rpt_eff + 30'(r_rec_in);
        end
    end

    // read address runs one ahead so the registered word matches r_idx
    assign n_idx = i_cmd.scan_next ? r_idx + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // entries never written read as their reset contents
    assign rd_start = r_rd_valid ? r_rd_word[31:16] : init_start(32'(r_idx));
    assign rd_len   = r_rd_valid ? r_rd_word[15:0]  : init_len(32'(r_idx));

    assign new_len   = rd_len - r_len;
    assign new_start = (new_len == '0) ? 16'd0 : rd_start + r_len;
    assign we        = i_cmd.wr_alloc | i_cmd.wr_free;
    assign wdata     = i_cmd.wr_free ? {r_block[15:0], r_len} : {new_start, new_len};

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_idx] <= wdata;
        end
        r_rd_word <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            for (int i = 0; i < ZONE_ENTRIES; i++) begin
                r_empty[i] <= (i >= INIT_COUNT);
            end
        end else begin
            r_rd_valid <= r_valid[n_idx];
            if (we) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.wr_free) begin
                r_empty[r_idx] <= 1'b0;
            end else if (i_cmd.wr_alloc && new_len == '0) begin
                r_empty[r_idx] <= 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    assign trial = {r_rem, r_quo[15]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start_a) begin
            r_quo <= rd_start;
            r_rem <= '0;
            r_dvs <= {2'b00, rpt_eff};
            r_cnt <= '0;
        end else if (i_cmd.div_start_b) begin
            r_rem <= '0;
            r_dvs <= tpc_eff;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[14:0], ge};
            r_rem <= ge ? diff[7:0] : trial[7:0];
            r_cnt <= r_cnt + 5'd1;
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_status <= ST_OK;
            r_cyl    <= '0;
            r_trk    <= '0;
            r_rec    <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.div_start_b) begin
                r_rec <= r_rem[5:0];
            end
            if (i_cmd.div_finish) begin
                r_cyl <= r_quo;
                r_trk <= r_rem;
            end
        end
        if (i_cmd.out_load) begin
            r_out.status       <= r_status;
            r_out.cylinder_out <= r_cyl;
            r_out.track_out    <= r_trk;
            r_out.record_out   <= r_rec;
        end
    end

    // action bit is looked at straight from the input while idle
    assign o_sts.is_free   = i_cmd.load_item ? (i_in_data.action == ACT_FREE) : r_free;
    assign o_sts.range_err = |r_block[29:16];
    assign o_sts.hit       = r_free ? r_empty[r_idx] : (rd_len >= r_len);
    assign o_sts.last      = (r_idx == LAST_IDX);
    assign o_sts.div_done  = r_cnt[4];

    assign o_out_data = r_out;

endmodule

// ===== src/first_fit_disk_zone_allocator.sv =====
// First-fit disk zone allocator top level.
//
// Input channel: i_in_valid / o_in_stall with i_in_data (action, length, position).
// An allocate takes the first table entry with enough free blocks and returns its
// start block as cylinder, track and record; a free puts the released block range
// into the first empty entry. Output channel: o_out_valid / i_out_stall with
// o_out_data, one result per accepted item, status first.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), index 0 records per
// track, index 1 tracks per cylinder; write only while no item is in flight.
// One item is worked on at a time; the table scan reads one entry per cycle from the
// table memory and the split into cylinder, track and record runs twice through a
// 16-step restoring divider.
// The output register holds a finished result while i_out_stall is high; the next
// item is taken meanwhile and waits at its end until the register is free.
// Reset (synchronous) restores the three initial zones and the default geometry
// and empties the output register; no clearing pass is needed.
`timescale 1ns / 1ps

module first_fit_disk_zone_allocator
    import ffdza_pkg::*;
#(
    parameter int unsigned ZONE_ENTRIES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    ffdza_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    ffdza_dp #(
        .ZONE_ENTRIES (ZONE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/ffdza_checker.sv =====
// port-level checker of the zone allocator and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffdza_checker
    import ffdza_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a stalled result holds
    `FFDZA_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data),
        "stalled result changed")

    // reset empties the output register
    `FFDZA_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // one item at a time: busy right after a transfer in
    `FFDZA_ASSERT(a_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall,
        "second item taken while busy")

    // error results carry no position
    `FFDZA_ASSERT(a_err_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.cylinder_out == '0
            && o_out_data.track_out == '0 && o_out_data.record_out == '0,
        "error result with position")

    // record is a remainder by at most 63
    `FFDZA_ASSERT(a_rec_range, i_clk, i_rst_n, o_out_valid |-> o_out_data.record_out != 6'd63,
        "record out of range")

endmodule

bind first_fit_disk_zone_allocator ffdza_checker u_ffdza_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
